### hdl/sha_pkg.sv
// Shared types and constants for the SHA-256 message hasher.
// Holds the transaction structs, the round constants and the initial hash values.
// No dependencies.
package sha_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } sha_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } sha_rsp_type;

   // One big-endian message word on its way from the front end to the core.
   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } sha_word_type;

   localparam logic       KIND_DATA   = 1'b0;
   localparam logic       KIND_FINISH = 1'b1;
   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [3:0] LEN_HI_IDX  = 4'd14;
   localparam logic [3:0] LEN_LO_IDX  = 4'd15;
   localparam logic [3:0] LEN_FIT_IDX = 4'd13;
   localparam logic [2:0] LAST_WORD   = 3'd7;

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] initial_hash(input logic [2:0] idx);
      logic [31:0] h;
      case (idx)
         3'd0: h = 32'h6a09e667;
         3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372;
         3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f;
         3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab;
         3'd7: h = 32'h5be0cd19;
         default: h = 32'h0;
      endcase
      return h;
   endfunction

endpackage

### hdl/sha_front.sv
// Front end: packs message bytes into big-endian words and generates the padding.
// Pushes words into the word queue toward the compression core.
// Depends on sha_pkg.
module sha_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  sha_pkg::sha_req_type req_item,
   output logic                 req_full,
   output logic                 q_push,
   output sha_pkg::sha_word_type q_data,
   input  logic                 q_full
);
   import sha_pkg::*;

   logic [23:0] part_ff, part_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic        pad_ff, pad_in;
   logic        first_ff, first_in;
   logic        lenph_ff, lenph_in;
   logic [3:0]  pidx_ff, pidx_in;
   logic        accept;
   logic [31:0] pad_word;

   assign req_full = pad_ff || q_full;
   assign accept   = req_push && !req_full;

   // First padding word: the bytes already held, then the pad byte, then zeros.
   always_comb begin
      case (fill_ff[1:0])
         2'd0:    pad_word = {PAD_BYTE, 24'h0};
         2'd1:    pad_word = {part_ff[7:0], PAD_BYTE, 16'h0};
         2'd2:    pad_word = {part_ff[15:0], PAD_BYTE, 8'h0};
         default: pad_word = {part_ff[23:0], PAD_BYTE};
      endcase
   end

   always_comb begin
      part_in  = part_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      pad_in   = pad_ff;
      first_in = first_ff;
      lenph_in = lenph_ff;
      pidx_in  = pidx_ff;
      q_push   = 1'b0;
      q_data   = '{word: {part_ff, req_item.data_byte}, last: 1'b0};

      if (pad_ff) begin
         if (first_ff) begin
            q_data.word = pad_word;
         end else if (lenph_ff && pidx_ff == LEN_HI_IDX) begin
            q_data.word = bits_ff[63:32];
         end else if (lenph_ff && pidx_ff == LEN_LO_IDX) begin
            q_data.word = bits_ff[31:0];
         end else begin
            q_data.word = 32'h0;
         end
         q_data.last = lenph_ff && pidx_ff == LEN_LO_IDX;
         if (!q_full) begin
            q_push   = 1'b1;
            first_in = 1'b0;
            pidx_in  = pidx_ff + 4'd1;
            if (pidx_ff == LEN_LO_IDX) begin
               if (lenph_ff) begin
                  pad_in  = 1'b0;
                  fill_in = 6'd0;
                  bits_in = 64'd0;
               end else begin
                  lenph_in = 1'b1;
               end
            end
         end
      end else if (accept) begin
         if (req_item.kind == KIND_DATA) begin
            part_in = {part_ff[15:0], req_item.data_byte};
            fill_in = fill_ff + 6'd1;
            bits_in = bits_ff + 64'd8;
            q_push  = (fill_ff[1:0] == 2'd3);
         end else begin
            pad_in   = 1'b1;
            first_in = 1'b1;
            pidx_in  = fill_ff[5:2];
            // The length fits in this block only if the pad byte lands before word 14.
            lenph_in = (fill_ff[5:2] <= LEN_FIT_IDX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= 6'd0;
         bits_ff  <= 64'd0;
         pad_ff   <= 1'b0;
         first_ff <= 1'b0;
         lenph_ff <= 1'b0;
         pidx_ff  <= 4'd0;
      end else begin
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         pad_ff   <= pad_in;
         first_ff <= first_in;
         lenph_ff <= lenph_in;
         pidx_ff  <= pidx_in;
      end
      part_ff <= part_in;
   end

endmodule

### hdl/sha_fifo.sv
// Short word queue between the front end and the compression core.
// Register based, first word shown on the read side while not empty.
// Depends on sha_pkg.
module sha_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  sha_pkg::sha_word_type wr_data,
   output logic                  full,
   input  logic                  rd_en,
   output sha_pkg::sha_word_type rd_data,
   output logic                  valid
);
   import sha_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sha_word_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_wr, do_rd;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign valid   = (cnt_ff != '0);
   assign rd_data = mem_ff[rptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && valid;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_wr) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

### hdl/sha_core.sv
// Compression core: one SHA-256 round per cycle when not stalled, with a 16-word message schedule.
// Takes words from the queue and presents the eight digest words after a message ends.
// Depends on sha_pkg.
module sha_core (
   input  logic                  clock,
   input  logic                  reset,
   input  sha_pkg::sha_word_type q_data,
   input  logic                  q_valid,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output sha_pkg::sha_rsp_type  rsp_item
);
   import sha_pkg::*;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_ADD,
      ST_EMIT
   } state_type;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   state_type   state_ff, state_in;
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [5:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic        last_ff, last_in;
   logic [31:0] sched, wt, t1, t2, sum1, sum0, choose, major, sig0, sig1;
   logic        loading, step;

   assign loading = (round_ff[5:4] == 2'd0);
   assign step    = (state_ff == ST_RUN) && (!loading || q_valid);
   assign q_pop   = (state_ff == ST_RUN) && loading && q_valid;

   assign rsp_empty = (state_ff != ST_EMIT);
   assign rsp_item  = '{digest_word: h_ff[idx_ff], word_index: idx_ff,
                        last: (idx_ff == LAST_WORD)};

   always_comb begin
      sig0   = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      sig1   = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      sched  = sig1 + w_ff[9] + sig0 + w_ff[0];
      wt     = loading ? q_data.word : sched;
      sum1   = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      choose = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1     = v_ff[7] + sum1 + choose + round_k(round_ff) + wt;
      sum0   = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      major  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2     = sum0 + major;
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      h_in     = h_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      case (state_ff)
         ST_RUN: begin
            if (step) begin
               for (int i = 0; i < 15; i++) begin
                  w_in[i] = w_ff[i+1];
               end
               w_in[15] = wt;
               v_in[7]  = v_ff[6];
               v_in[6]  = v_ff[5];
               v_in[5]  = v_ff[4];
               v_in[4]  = v_ff[3] + t1;
               v_in[3]  = v_ff[2];
               v_in[2]  = v_ff[1];
               v_in[1]  = v_ff[0];
               v_in[0]  = t1 + t2;
               round_in = round_ff + 6'd1;
               if (round_ff == 6'd15) begin
                  last_in = q_data.last;
               end
               if (round_ff == 6'd63) begin
                  state_in = ST_ADD;
               end
            end
         end
         ST_ADD: begin
            // The working variables start the next block from the updated hash.
            for (int i = 0; i < 8; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
               v_in[i] = h_ff[i] + v_ff[i];
            end
            idx_in   = 3'd0;
            state_in = last_ff ? ST_EMIT : ST_RUN;
         end
         ST_EMIT: begin
            if (rsp_pop) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == LAST_WORD) begin
                  for (int i = 0; i < 8; i++) begin
                     h_in[i] = initial_hash(3'(i));
                     v_in[i] = initial_hash(3'(i));
                  end
                  last_in  = 1'b0;
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         round_ff <= 6'd0;
         idx_ff   <= 3'd0;
         last_ff  <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= initial_hash(3'(i));
            v_ff[i] <= initial_hash(3'(i));
         end
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         last_ff  <= last_in;
         h_ff     <= h_in;
         v_ff     <= v_in;
      end
      w_ff <= w_in;
   end

endmodule

### hdl/sha256_message_hasher.sv
// SHA-256 message hasher: bytes in, eight digest words out per finished message.
// Throughput: bytes are taken one per cycle while the word queue has room and no padding is
// under way, but a block loads only as fast as the front end packs words (one per 4 bytes),
// then runs 48 more rounds and the hash update.
// Finish: 3 to 18 padding words, one or two blocks, then 8 digest words.
// Reset (synchronous): hash state set to the initial values, byte and bit counts cleared.
module sha256_message_hasher #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sha_pkg::sha_req_type req_item,
   output logic                 full,
   output logic                 empty,
   input  logic                 pop,
   output sha_pkg::sha_rsp_type rsp_item
);
   import sha_pkg::*;

   sha_word_type fw_data, q_data;
   logic         fw_push, q_full, q_valid, q_pop;

   sha_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (push),
      .req_item (req_item),
      .req_full (full),
      .q_push   (fw_push),
      .q_data   (fw_data),
      .q_full   (q_full)
   );

   sha_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fw_push),
      .wr_data (fw_data),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .valid   (q_valid)
   );

   sha_core u_core (
      .clock     (clock),
      .reset     (reset),
      .q_data    (q_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp_item  (rsp_item)
   );

endmodule

### bench/tb_top.sv
// Self-checking testbench for sha256_message_hasher: byte messages in, digest words out.
// Holds a SHA-256 predictor, a queue-fed driver and a result monitor with random stalls.
// Depends on sha_pkg and the sha256_message_hasher RTL.
`timescale 1ns / 1ps

module tb_top;
   import sha_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 300;
   localparam int RANDOM_ITEMS = 125;
   localparam int QUIET_FROM = 250;
   localparam int QUIET_TO = 550;
   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [255:0] START_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [2047:0] ROUND_CONSTS = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   logic        clock;
   logic        reset;
   logic        push;
   sha_req_type req_item;
   logic        full;
   logic        empty;
   logic        pop;
   sha_rsp_type rsp_item;

   sha_req_type pending_bytes[$];
   sha_rsp_type digest_words_due[$];
   logic        push_waiting;
   int          cycle_count;
   int          mismatch_count;

   // Hash state of the message in progress.
   logic [31:0] hash_state[8];
   logic [7:0]  block_bytes[64];
   int          fill_count;
   logic [63:0] bit_count;

   sha256_message_hasher DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .req_item(req_item),
      .full(full),
      .empty(empty),
      .pop(pop),
      .rsp_item(rsp_item)
   );

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void clear_hash_state();
      for (int i = 0; i < 8; i++) begin
         hash_state[i] = START_HASH[(7 - i) * 32 +: 32];
      end
      for (int i = 0; i < 64; i++) begin
         block_bytes[i] = 8'h00;
      end
      fill_count = 0;
      bit_count = 64'd0;
   endfunction

   function automatic void compress_buffer();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] s0, s1, t1, t2, ch, maj;
      for (int i = 0; i < 16; i++) begin
         w[i] = {block_bytes[4 * i], block_bytes[4 * i + 1],
                 block_bytes[4 * i + 2], block_bytes[4 * i + 3]};
      end
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i - 15], 7) ^ ror32(w[i - 15], 18) ^ (w[i - 15] >> 3);
         s1 = ror32(w[i - 2], 17) ^ ror32(w[i - 2], 19) ^ (w[i - 2] >> 10);
         w[i] = s1 + w[i - 7] + s0 + w[i - 16];
      end
      for (int i = 0; i < 8; i++) begin
         v[i] = hash_state[i];
      end
      for (int i = 0; i < 64; i++) begin
         s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
         ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
         t1 = v[7] + s1 + ch + ROUND_CONSTS[(63 - i) * 32 +: 32] + w[i];
         s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
         maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         t2 = s0 + maj;
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) begin
         hash_state[i] = hash_state[i] + v[i];
      end
   endfunction

   // Absorbs one accepted transaction; a finish queues the eight digest words.
   function automatic void absorb_byte(input sha_req_type item);
      int pos;
      sha_rsp_type word;
      if (item.kind == KIND_DATA) begin
         block_bytes[fill_count] = item.data_byte;
         fill_count++;
         if (fill_count == 64) begin
            compress_buffer();
            bit_count = bit_count + 64'd512;
            fill_count = 0;
         end
      end else begin
         pos = fill_count;
         bit_count = bit_count + 64'(pos * 8);
         block_bytes[pos] = PAD_MARK;
         pos++;
         // Fewer than eight bytes left for the length: pad out and spill into a second block.
         if (pos > 56) begin
            while (pos < 64) begin
               block_bytes[pos] = 8'h00;
               pos++;
            end
            compress_buffer();
            pos = 0;
         end
         while (pos < 56) begin
            block_bytes[pos] = 8'h00;
            pos++;
         end
         for (int i = 0; i < 8; i++) begin
            block_bytes[63 - i] = bit_count[8 * i +: 8];
         end
         compress_buffer();
         for (int i = 0; i < 8; i++) begin
            word.digest_word = hash_state[i];
            word.word_index = 3'(i);
            word.last = (i == 7);
            digest_words_due.push_back(word);
         end
         clear_hash_state();
      end
   endfunction

   function automatic bit take_gap();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) begin
         return 1'b0;
      end
      return $urandom_range(99) < 35;
   endfunction

   function automatic void queue_item(input logic kind, input logic [7:0] value);
      sha_req_type item;
      item.kind = kind;
      item.data_byte = value;
      pending_bytes.push_back(item);
   endfunction

   // A message of random bytes followed by a finish with a random, ignored data byte.
   function automatic int queue_message(input int length);
      for (int i = 0; i < length; i++) begin
         queue_item(KIND_DATA, 8'($urandom_range(255)));
      end
      queue_item(KIND_FINISH, 8'($urandom_range(255)));
      return length + 1;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sha256_message_hasher: mismatch");
         $finish;
      end
   end

   // Driver: holds a refused transaction, otherwise offers the next byte unless stalling.
   always @(negedge clock) begin
      if (reset || pending_bytes.size() == 0) begin
         push <= 1'b0;
      end else if (!push_waiting) begin
         if (take_gap()) begin
            push <= 1'b0;
         end else begin
            push <= 1'b1;
            req_item <= pending_bytes[0];
         end
      end
   end

   always @(negedge clock) begin
      pop <= !reset && !take_gap();
   end

   // Monitor: feeds accepted inputs to the predictor and checks accepted digest words.
   always @(posedge clock) begin
      sha_rsp_type want;
      push_waiting <= push && full;
      if (!reset && push && !full) begin
         absorb_byte(req_item);
         void'(pending_bytes.pop_front());
      end
      if (!reset && pop && !empty) begin
         if (digest_words_due.size() == 0) begin
            $error("unexpected digest word %h at index %0d",
                   rsp_item.digest_word, rsp_item.word_index);
            mismatch_count++;
         end else begin
            want = digest_words_due.pop_front();
            if (rsp_item.digest_word !== want.digest_word) begin
               $error("digest_word: expected %h, actual %h",
                      want.digest_word, rsp_item.digest_word);
               mismatch_count++;
            end
            if (rsp_item.word_index !== want.word_index) begin
               $error("word_index: expected %0d, actual %0d",
                      want.word_index, rsp_item.word_index);
               mismatch_count++;
            end
            if (rsp_item.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_item.last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int random_items;
      int length;
      reset = 1'b1;
      push = 1'b0;
      pop = 1'b0;
      req_item = '0;
      push_waiting = 1'b0;
      cycle_count = 0;
      mismatch_count = 0;
      random_items = 0;
      clear_hash_state();

      // Empty message, with the ignored data byte at both extremes.
      queue_item(KIND_FINISH, 8'hFF);
      queue_item(KIND_FINISH, 8'h00);
      // Byte extremes inside a short message.
      queue_item(KIND_DATA, 8'h00);
      queue_item(KIND_DATA, 8'hFF);
      queue_item(KIND_DATA, 8'h61);
      queue_item(KIND_FINISH, 8'h5A);
      // The classic three-byte message.
      queue_item(KIND_DATA, 8'h61);
      queue_item(KIND_DATA, 8'h62);
      queue_item(KIND_DATA, 8'h63);
      queue_item(KIND_FINISH, 8'hA5);

      // Padding boundaries: full block then finish, and a length that spills.
      random_items += queue_message(64);
      random_items += queue_message(56);
      while (random_items < RANDOM_ITEMS) begin
         length = $urandom_range(15);
         random_items += queue_message(length);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || digest_words_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sha256_message_hasher: match");
      end else begin
         $display("sha256_message_hasher: mismatch");
      end
      $finish;
   end

endmodule

### sha256_message_hasher.f
hdl/sha_pkg.sv
hdl/sha_front.sv
hdl/sha_fifo.sv
hdl/sha_core.sv
hdl/sha256_message_hasher.sv
bench/tb_top.sv
